/* rtl/core/hwc_pkg.sv */
// hwc_pkg: word codes, register indexes and stage types for the word-clock phrase core.
// No dependencies; imported by the interfaces, the core, its checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package hwc_pkg;

    localparam int WORD_W = 6;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int MAX_WORDS = 7;

    // word codes
    localparam logic [WORD_W-1:0] W_DEL         = 6'd0;
    localparam logic [WORD_W-1:0] W_EJFEL       = 6'd1;
    localparam logic [WORD_W-1:0] W_EJJEL       = 6'd2;
    localparam logic [WORD_W-1:0] W_HAJNAL      = 6'd3;
    localparam logic [WORD_W-1:0] W_REGGEL      = 6'd4;
    localparam logic [WORD_W-1:0] W_DELELOTT    = 6'd5;
    localparam logic [WORD_W-1:0] W_DELUTAN     = 6'd6;
    localparam logic [WORD_W-1:0] W_ESTE        = 6'd7;
    localparam logic [WORD_W-1:0] W_HAROMNEGYED = 6'd8;
    localparam logic [WORD_W-1:0] W_NEGYED      = 6'd9;
    localparam logic [WORD_W-1:0] W_FEL         = 6'd10;
    localparam logic [WORD_W-1:0] W_HOUR_BASE   = 6'd11;
    localparam logic [WORD_W-1:0] W_MIN_BASE    = 6'd23;
    localparam logic [WORD_W-1:0] W_MULT        = 6'd31;
    localparam logic [WORD_W-1:0] W_LESZ        = 6'd32;
    localparam logic [WORD_W-1:0] W_PERCCEL     = 6'd33;
    localparam logic [WORD_W-1:0] W_PERC        = 6'd34;
    localparam logic [WORD_W-1:0] W_MULVA       = 6'd35;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DAWN     = 3'd0;
    localparam logic [2:0] REG_MORNING  = 3'd1;
    localparam logic [2:0] REG_FORENOON = 3'd2;
    localparam logic [2:0] REG_NOON     = 3'd3;
    localparam logic [2:0] REG_EVENING  = 3'd4;
    localparam logic [2:0] REG_NIGHT    = 3'd5;

    // minute reference points
    typedef enum logic [2:0] {
        REF_HOUR    = 3'd0,
        REF_QUARTER = 3'd1,
        REF_HALF    = 3'd2,
        REF_THREEQ  = 3'd3,
        REF_NEXT    = 3'd4
    } t_ref;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        t_ref              refp;
    } t_s1;

    typedef struct packed {
        logic [HOUR_W-1:0] h;
        t_ref              refp;
        logic              past;
        logic              early;
        logic [MIN_W-1:0]  mag;
    } t_s2;

    typedef struct packed {
        logic              has_period;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] hour_word;
        t_ref              refp;
        logic              past;
        logic              early;
        logic              has_min;
        logic [WORD_W-1:0] min_word;
    } t_s3;

endpackage

`default_nettype wire

/* rtl/core/hwc_in_if.sv */
// hwc_in_if: input channel carrying one time sample (hour, minute).
// Depends on hwc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hwc_in_if
    import hwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] hour_in;
    logic [MIN_W-1:0]  minute_in;

    modport source (output valid, output hour_in, output minute_in, input ready);
    modport sink   (input valid, input hour_in, input minute_in, output ready);
endinterface

`default_nettype wire

/* rtl/core/hwc_out_if.sv */
// hwc_out_if: output channel carrying one word code and its end-of-phrase flag.
// Depends on hwc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hwc_out_if
    import hwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/hungarian_word_clock_phrase_core.sv */
// hungarian_word_clock_phrase_core: time sample in, Hungarian spoken-time word codes out.
// Depends on hwc_pkg, hwc_in_if and hwc_out_if.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------
//  i_in    | in  | valid / ready     | hour_in[4:0], minute_in[5:0]
//  o_out   | out | valid / ready     | word[5:0], last
//  apb     | in  | psel/penable/...  | 6 x 5-bit hour boundaries
//
// Four register stages (normalize, reference hour, word pick, phrase build) feed a
// word shifter, which presents the first word of a phrase as soon as the phrase is loaded.
// A phrase of n words (1..7) holds the shifter until its last word is taken; a waiting
// phrase loads as that word leaves, so the single-word output port sets the sample rate.
// Synchronous active-low reset empties all stages; configuration resets to 3,6,9,12,18,22.
// A stall at the output holds the current word and backs up the stages; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module hungarian_word_clock_phrase_core
    import hwc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    hwc_in_if.sink      i_in,
    hwc_out_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic [HOUR_W-1:0] r_dawn, r_morning, r_forenoon, r_noon, r_evening, r_night;
    logic [2:0]        cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dawn     <= 5'd3;
            r_morning  <= 5'd6;
            r_forenoon <= 5'd9;
            r_noon     <= 5'd12;
            r_evening  <= 5'd18;
            r_night    <= 5'd22;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DAWN:     r_dawn     <= pwdata[HOUR_W-1:0];
                REG_MORNING:  r_morning  <= pwdata[HOUR_W-1:0];
                REG_FORENOON: r_forenoon <= pwdata[HOUR_W-1:0];
                REG_NOON:     r_noon     <= pwdata[HOUR_W-1:0];
                REG_EVENING:  r_evening  <= pwdata[HOUR_W-1:0];
                REG_NIGHT:    r_night    <= pwdata[HOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_DAWN:     prdata = {27'd0, r_dawn};
            REG_MORNING:  prdata = {27'd0, r_morning};
            REG_FORENOON: prdata = {27'd0, r_forenoon};
            REG_NOON:     prdata = {27'd0, r_noon};
            REG_EVENING:  prdata = {27'd0, r_evening};
            REG_NIGHT:    prdata = {27'd0, r_night};
            default:      prdata = '0;
        endcase
    end

    // ---------------- stage handshake ----------------
    logic r1_v, r2_v, r3_v, r4_v, r_sv;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, ser_rdy;
    logic [2:0] r_left;

    assign ser_rdy = !r_sv || (o_out.ready && (r_left == 3'd0));
    assign s4_rdy  = !r4_v || ser_rdy;
    assign s3_rdy  = !r3_v || s4_rdy;
    assign s2_rdy  = !r2_v || s3_rdy;
    assign s1_rdy  = !r1_v || s2_rdy;
    assign i_in.ready = s1_rdy;

    // ---------------- stage 1: normalize, pick reference ----------------
    t_s1 r1, n1;

    always_comb begin
        n1.hour = (i_in.hour_in >= 5'd24) ? i_in.hour_in - 5'd24 : i_in.hour_in;
        n1.minute = (i_in.minute_in > 6'd59) ? 6'd59 : i_in.minute_in;
        if (n1.minute <= 6'd8)       n1.refp = REF_HOUR;
        else if (n1.minute <= 6'd23) n1.refp = REF_QUARTER;
        else if (n1.minute <= 6'd38) n1.refp = REF_HALF;
        else if (n1.minute <= 6'd53) n1.refp = REF_THREEQ;
        else                         n1.refp = REF_NEXT;
    end

    // ---------------- stage 2: named hour, offset from reference ----------------
    t_s2 r2, n2;
    logic [6:0] target;
    logic [6:0] diff;

    always_comb begin
        case (r1.refp)
            REF_HOUR:    target = 7'd0;
            REF_QUARTER: target = 7'd15;
            REF_HALF:    target = 7'd30;
            REF_THREEQ:  target = 7'd45;
            REF_NEXT:    target = 7'd60;
            default:     target = 7'd0;
        endcase
        diff = {1'b0, r1.minute} - target;
        n2.refp  = r1.refp;
        n2.past  = !diff[6] && (diff != 7'd0);
        n2.early = diff[6];
        n2.mag   = diff[6] ? 6'(7'd0 - diff) : diff[5:0];
        if (r1.refp == REF_HOUR)  n2.h = r1.hour;
        else if (r1.hour >= 5'd23) n2.h = 5'd0;
        else                       n2.h = r1.hour + 5'd1;
    end

    // ---------------- stage 3: period, hour and minute words ----------------
    t_s3 r3, n3;

    always_comb begin
        logic [HOUR_W-1:0] h;
        h = r2.h;
        if (h >= r_dawn && h < r_morning)          n3.period = W_HAJNAL;
        else if (h >= r_morning && h < r_forenoon) n3.period = W_REGGEL;
        else if (h >= r_forenoon && h < r_noon)    n3.period = W_DELELOTT;
        else if (h == 5'd12)                       n3.period = W_DEL;
        else if (h > 5'd12 && h < r_evening)       n3.period = W_DELUTAN;
        else if (h >= r_evening && h < r_night)    n3.period = W_ESTE;
        else                                       n3.period = W_EJJEL;
        n3.has_period = (h != 5'd0) && (h != 5'd12);
        if (h == 5'd12)     n3.hour_word = W_DEL;
        else if (h == 5'd0) n3.hour_word = W_EJFEL;
        else if (h > 5'd12) n3.hour_word = W_HOUR_BASE + {1'b0, h} - 6'd13;
        else                n3.hour_word = W_HOUR_BASE + {1'b0, h} - 6'd1;
        n3.refp     = r2.refp;
        n3.past     = r2.past;
        n3.early    = r2.early;
        n3.has_min  = (r2.mag <= 6'd8);
        n3.min_word = W_MIN_BASE + r2.mag - 6'd1;
    end

    // ---------------- stage 4: phrase build ----------------
    logic [WORD_W-1:0] r4_words [MAX_WORDS];
    logic [WORD_W-1:0] n4_words [MAX_WORDS];
    logic [2:0]        r4_cnt, n4_cnt;

    always_comb begin
        logic [2:0] n;
        n = 3'd0;
        for (int k = 0; k < MAX_WORDS; k++) n4_words[k] = W_DEL;
        if (r3.has_period) begin
            n4_words[n] = r3.period;
            n = n + 3'd1;
        end
        case (r3.refp)
            REF_QUARTER: begin
                n4_words[n] = W_NEGYED;
                n = n + 3'd1;
            end
            REF_HALF: begin
                n4_words[n] = W_FEL;
                n = n + 3'd1;
            end
            REF_THREEQ: begin
                n4_words[n] = W_HAROMNEGYED;
                n = n + 3'd1;
            end
            default: ;
        endcase
        n4_words[n] = r3.hour_word;
        if (r3.past || r3.early) begin
            n = n + 3'd1;
            n4_words[n] = r3.past ? W_MULT : W_LESZ;
            if (r3.has_min) begin
                n = n + 3'd1;
                n4_words[n] = r3.min_word;
            end
            n = n + 3'd1;
            n4_words[n] = r3.past ? W_PERCCEL : W_PERC;
            if (r3.early) begin
                n = n + 3'd1;
                n4_words[n] = W_MULVA;
            end
        end
        n4_cnt = n;  // index of the final word
    end

    // ---------------- stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (s1_rdy) r1_v <= i_in.valid;
            if (s2_rdy) r2_v <= r1_v;
            if (s3_rdy) r3_v <= r2_v;
            if (s4_rdy) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) r1 <= n1;
        if (s2_rdy) r2 <= n2;
        if (s3_rdy) r3 <= n3;
        if (s4_rdy) begin
            r4_words <= n4_words;
            r4_cnt   <= n4_cnt;
        end
    end

    // ---------------- word shifter ----------------
    logic [WORD_W-1:0] r_sh [MAX_WORDS];
    logic              ser_load, ser_adv;

    assign ser_load = r4_v && ser_rdy;
    assign ser_adv  = r_sv && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            r_left <= 3'd0;
        end else if (ser_load) begin
            r_sv   <= 1'b1;
            r_left <= r4_cnt;
        end else if (ser_adv) begin
            // drop the phrase after its last word, else advance
            if (r_left == 3'd0) r_sv <= 1'b0;
            else                r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_sh <= r4_words;
        end else if (ser_adv) begin
            for (int k = 0; k < MAX_WORDS - 1; k++) r_sh[k] <= r_sh[k+1];
            r_sh[MAX_WORDS-1] <= W_DEL;
        end
    end

    assign o_out.valid = r_sv;
    assign o_out.word  = r_sh[0];
    assign o_out.last  = (r_left == 3'd0);

endmodule

`default_nettype wire

/* rtl/core/hwc_core_chk.sv */
// hwc_core_chk: port-level checks on the word-clock phrase core, bound to the top level.
// Depends on hwc_pkg for word codes.
`timescale 1ns / 1ps
`default_nettype none

module hwc_core_chk
    import hwc_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [WORD_W-1:0] i_out_word,
    input wire              i_out_last
);

    logic acc;
    assign acc = i_out_valid && i_out_ready;

    // hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_word) && $stable(i_out_last)))
        else $error("stalled output word changed");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_word <= W_MULVA))
        else $error("word code out of range");

    // suffix terminators always close the phrase
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_out_word == W_PERCCEL || i_out_word == W_MULVA)) |-> i_out_last)
        else $error("phrase terminator without last");

    // period, quarter and connective words never end a phrase
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ((i_out_word >= W_EJJEL && i_out_word <= W_FEL) ||
                 i_out_word == W_MULT || i_out_word == W_LESZ)) |-> !i_out_last)
        else $error("phrase ended on a leading word");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind hungarian_word_clock_phrase_core hwc_core_chk u_hwc_core_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.word),
    .i_out_last  (o_out.last)
);

`default_nettype wire

/* sim/hungarian_word_clock_phrase_core_test.sv */
// Testbench for hungarian_word_clock_phrase_core: drives time samples and boundary writes,
// and predicts each phrase so every word and last flag can be checked in order.
// Depends on hwc_pkg, hwc_in_if, hwc_out_if and the core.
`timescale 1ns / 1ps

module hungarian_word_clock_phrase_core_test;
    import hwc_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_spoken_word;

    class phrase_scoreboard;
        int           bounds[6];
        t_spoken_word pending_words[$];
        int           mismatches;
        int           samples_noted;
        int           words_checked;

        function new();
            bounds = '{3, 6, 9, 12, 18, 22};
        endfunction

        function void set_boundary(int idx, int hr);
            bounds[idx] = hr;
        endfunction

        function logic [WORD_W-1:0] period_of(int h);
            if (h >= bounds[REG_DAWN] && h < bounds[REG_MORNING]) return W_HAJNAL;
            if (h >= bounds[REG_MORNING] && h < bounds[REG_FORENOON]) return W_REGGEL;
            if (h >= bounds[REG_FORENOON] && h < bounds[REG_NOON]) return W_DELELOTT;
            if (h == 12) return W_DEL;
            if (h > 12 && h < bounds[REG_EVENING]) return W_DELUTAN;
            if (h >= bounds[REG_EVENING] && h < bounds[REG_NIGHT]) return W_ESTE;
            return W_EJJEL;
        endfunction

        // Build the spoken phrase for one sample and queue its words.
        function void note_time(logic [HOUR_W-1:0] hour_in, logic [MIN_W-1:0] minute_in);
            int                hr, mn, h, hn, target, diff, k;
            t_ref              refp;
            logic [WORD_W-1:0] phrase[$];
            hr = int'(hour_in);
            mn = int'(minute_in);
            if (hr >= 24) hr -= 24;
            if (mn > 59) mn = 59;
            if (mn <= 8) begin
                refp = REF_HOUR; target = 0;
            end else if (mn <= 23) begin
                refp = REF_QUARTER; target = 15;
            end else if (mn <= 38) begin
                refp = REF_HALF; target = 30;
            end else if (mn <= 53) begin
                refp = REF_THREEQ; target = 45;
            end else begin
                refp = REF_NEXT; target = 60;
            end
            // every reference point past the hour names the following hour
            h = (refp == REF_HOUR) ? hr : (hr + 1) % 24;
            if (h != 0 && h != 12) phrase.push_back(period_of(h));
            case (refp)
                REF_QUARTER: phrase.push_back(W_NEGYED);
                REF_HALF:    phrase.push_back(W_FEL);
                REF_THREEQ:  phrase.push_back(W_HAROMNEGYED);
                default: ;
            endcase
            if (h == 12) phrase.push_back(W_DEL);
            else if (h == 0) phrase.push_back(W_EJFEL);
            else begin
                hn = (h > 12) ? h - 12 : h;
                phrase.push_back(W_HOUR_BASE + WORD_W'(hn - 1));
            end
            diff = mn - target;
            if (diff > 0) begin
                phrase.push_back(W_MULT);
                if (diff <= 8) phrase.push_back(W_MIN_BASE + WORD_W'(diff - 1));
                phrase.push_back(W_PERCCEL);
            end else if (diff < 0) begin
                diff = -diff;
                phrase.push_back(W_LESZ);
                if (diff <= 8) phrase.push_back(W_MIN_BASE + WORD_W'(diff - 1));
                phrase.push_back(W_PERC);
                phrase.push_back(W_MULVA);
            end
            for (k = 0; k < phrase.size(); k++)
                pending_words.push_back('{phrase[k], k == phrase.size() - 1});
            samples_noted++;
        endfunction

        function void check_word(logic [WORD_W-1:0] word, logic last);
            t_spoken_word want;
            if (pending_words.size() == 0) begin
                $error("word %0d (last %0b) arrived with no phrase pending", word, last);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (word !== want.word) begin
                $error("field word: expected %0d, actual %0d", want.word, word);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("field last: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    hwc_in_if  time_ch();
    hwc_out_if word_ch();

    hungarian_word_clock_phrase_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (time_ch),
        .o_out   (word_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    phrase_scoreboard board = new();
    bit gaps_on;
    bit hold_request;
    int settings_used;
    int idle_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        time_ch.valid = 1'b0;
        time_ch.hour_in = '0;
        time_ch.minute_in = '0;
        word_ch.ready = 1'b0;
    end

    // Word sink: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                word_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 4);
                word_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                word_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (word_ch.valid && word_ch.ready) board.check_word(word_ch.word, word_ch.last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (time_ch.valid && time_ch.ready) || (word_ch.valid && word_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("hungarian_word_clock_phrase_core test failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_time(input logic [HOUR_W-1:0] hr, input logic [MIN_W-1:0] mn);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            time_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        time_ch.valid <= 1'b1;
        time_ch.hour_in <= hr;
        time_ch.minute_in <= mn;
        do @(posedge i_clk); while (!time_ch.ready);
        board.note_time(hr, mn);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [HOUR_W-1:0] hr;
        logic [MIN_W-1:0]  mn;
        repeat (count) begin
            hr = ($urandom_range(0, 7) == 0) ? HOUR_W'($urandom_range(24, 31))
                                             : HOUR_W'($urandom_range(0, 23));
            mn = ($urandom_range(0, 7) == 0) ? MIN_W'($urandom_range(60, 63))
                                             : MIN_W'($urandom_range(0, 59));
            send_time(hr, mn);
        end
    endtask

    // Drop valid, drain every pending word, then let the stages empty.
    task automatic settle();
        time_ch.valid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_boundary(input logic [2:0] idx, input logic [4:0] hr);
        logic [31:0] data;
        data = {27'($urandom()), hr};
        if ($urandom_range(0, 1) == 0) data[31:5] = '0;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_boundary(int'(idx), int'(hr));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_bounds(input int b0, b1, b2, b3, b4, b5);
        write_boundary(REG_DAWN, 5'(b0));
        write_boundary(REG_MORNING, 5'(b1));
        write_boundary(REG_FORENOON, 5'(b2));
        write_boundary(REG_NOON, 5'(b3));
        write_boundary(REG_EVENING, 5'(b4));
        write_boundary(REG_NIGHT, 5'(b5));
        settings_used++;
        @(negedge i_clk);
    endtask

    initial begin
        int dir_h[25] = '{0, 12, 23, 11, 24, 31, 7, 7, 7, 7, 7, 7, 7,
                          7, 7, 7, 7, 7, 13, 18, 22, 3, 6, 9, 16};
        int dir_m[25] = '{0, 0, 59, 54, 0, 63, 8, 9, 15, 23, 24, 30, 38,
                          39, 45, 53, 54, 60, 5, 20, 40, 1, 50, 35, 31};
        int k;
        settings_used = 1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on = 1'b1;
        @(negedge i_clk);

        // reset boundaries: exact hours, noon, midnight, wrap and saturation
        for (k = 0; k < 25; k++) send_time(HOUR_W'(dir_h[k]), MIN_W'(dir_m[k]));
        send_random(40);
        settle();

        write_bounds(0, 0, 0, 0, 0, 0);
        send_random(25);
        settle();

        write_bounds(24, 24, 24, 24, 24, 24);
        send_random(25);
        settle();

        // values past 24 are compared as they are
        write_bounds(31, 0, 31, 0, 31, 31);
        send_random(20);
        settle();

        write_bounds($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        hold_request = 1'b1;
        send_random(30);
        settle();

        write_bounds($urandom_range(0, 8), $urandom_range(4, 12), $urandom_range(8, 14),
                     $urandom_range(10, 16), $urandom_range(14, 22), $urandom_range(18, 24));
        send_random(20);
        settle();

        // final stretch back at reset values, full throughput
        write_bounds(3, 6, 9, 12, 18, 22);
        gaps_on = 1'b0;
        send_random(40);
        settle();

        if (board.pending_words.size() != 0) begin
            $error("%0d words still pending at end of run", board.pending_words.size());
            board.mismatches++;
        end
        $display("Covered %0d time samples and %0d words across %0d boundary settings,",
                 board.samples_noted, board.words_checked, settings_used);
        $display("including a long output hold-off and a stretch with no idling.");
        if (board.mismatches == 0) begin
            $display("hungarian_word_clock_phrase_core test passed");
        end else begin
            $display("hungarian_word_clock_phrase_core test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/hwc_pkg.sv
rtl/core/hwc_in_if.sv
rtl/core/hwc_out_if.sv
rtl/core/hungarian_word_clock_phrase_core.sv
rtl/core/hwc_core_chk.sv
sim/hungarian_word_clock_phrase_core_test.sv
